// File: hdl/xcbr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package xcbr_pkg;

    localparam int CNT_W = 11;
    localparam int DEF_LONG_BYTES = 1024;
    localparam int DEF_SHORT_BYTES = 128;

    localparam logic [15:0] POLL_RESET = 16'd500;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] SAT_MAX = 16'hFFFF;

    localparam logic [1:0] KIND_ARM = 2'd0;
    localparam logic [1:0] KIND_BYTE = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_HUNT = 3'd1;
    localparam logic [2:0] PH_NUMBER = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_CRC = 3'd4;

    localparam logic [7:0] C_SOH = 8'h01;
    localparam logic [7:0] C_STX = 8'h02;
    localparam logic [7:0] C_ETX = 8'h03;
    localparam logic [7:0] C_EOT = 8'h04;
    localparam logic [7:0] C_ACK = 8'h06;
    localparam logic [7:0] C_NAK = 8'h15;
    localparam logic [7:0] C_CAN = 8'h18;
    localparam logic [7:0] C_REQ = 8'h43;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_EOT = 3'd1;
    localparam logic [2:0] ST_CANCEL = 3'd2;
    localparam logic [2:0] ST_BAD_NUM = 3'd3;
    localparam logic [2:0] ST_BAD_CRC = 3'd4;
    localparam logic [2:0] ST_TIMEOUT = 3'd5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  rx_byte;
        logic [7:0]  expected_block;
        logic [15:0] seg_timeout;
    } t_item;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_code;
        logic       data_valid;
        logic [7:0] data_byte;
        logic       done_res;
        logic [2:0] status;
        logic       long_block;
    } t_res;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == SAT_MAX) ? v : v + 16'd1;
    endfunction

endpackage

`default_nettype wire

// File: hdl/xcbr_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface xcbr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  rx_byte;
    logic [7:0]  expected_block;
    logic [15:0] seg_timeout;

    modport source (output valid, kind, rx_byte, expected_block, seg_timeout, input ready);
    modport sink (input valid, kind, rx_byte, expected_block, seg_timeout, output ready);
endinterface

interface xcbr_out_if;
    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_code;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       done_res;
    logic [2:0] status;
    logic       long_block;

    modport source (output valid, tx_valid, tx_code, data_valid, data_byte, done_res,
                    status, long_block, input ready);
    modport sink (input valid, tx_valid, tx_code, data_valid, data_byte, done_res,
                  status, long_block, output ready);
endinterface

`default_nettype wire

// File: hdl/xcbr_core.sv
`timescale 1ns / 1ps
`default_nettype none

module xcbr_core #(
    parameter int LONG_BLOCK_BYTES = xcbr_pkg::DEF_LONG_BYTES,
    parameter int SHORT_BLOCK_BYTES = xcbr_pkg::DEF_SHORT_BYTES
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire xcbr_pkg::t_item  i_item,
    input  wire logic [15:0]      i_poll_interval,
    output xcbr_pkg::t_res        o_res
);
    import xcbr_pkg::*;

    localparam logic [CNT_W-1:0] LONG_CNT = CNT_W'(LONG_BLOCK_BYTES);
    localparam logic [CNT_W-1:0] SHORT_CNT = CNT_W'(SHORT_BLOCK_BYTES);

    logic [2:0]       r_phase, n_phase;
    logic [CNT_W-1:0] r_byte_count, n_byte_count;
    logic [15:0]      r_crc_acc, n_crc_acc;
    logic [7:0]       r_expected_number, n_expected_number;
    logic [7:0]       r_got_number, n_got_number;
    logic [7:0]       r_got_crc_high, n_got_crc_high;
    logic             r_is_long, n_is_long;
    logic [15:0]      r_segment_timeout, n_segment_timeout;
    logic [15:0]      r_segment_elapsed, n_segment_elapsed;
    logic [15:0]      r_poll_elapsed, n_poll_elapsed;

    logic [CNT_W-1:0] block_size;
    logic [CNT_W-1:0] cnt_inc;
    logic [15:0]      crc_next;
    logic [15:0]      seg_inc;
    logic [15:0]      poll_inc;

    assign block_size = r_is_long ? LONG_CNT : SHORT_CNT;
    assign cnt_inc = r_byte_count + CNT_W'(1);
    assign crc_next = crc_byte(r_crc_acc, i_item.rx_byte);
    assign seg_inc = sat_inc(r_segment_elapsed);
    assign poll_inc = sat_inc(r_poll_elapsed);

    always_comb begin
        n_phase = r_phase;
        n_byte_count = r_byte_count;
        n_crc_acc = r_crc_acc;
        n_expected_number = r_expected_number;
        n_got_number = r_got_number;
        n_got_crc_high = r_got_crc_high;
        n_is_long = r_is_long;
        n_segment_timeout = r_segment_timeout;
        n_segment_elapsed = r_segment_elapsed;
        n_poll_elapsed = r_poll_elapsed;
        o_res = '0;

        if (r_phase == PH_NUMBER || r_phase == PH_DATA || r_phase == PH_CRC) begin
            o_res.long_block = r_is_long;
        end

        case (i_item.kind)
            KIND_ARM: begin
                n_expected_number = i_item.expected_block;
                n_segment_timeout = i_item.seg_timeout;
                n_byte_count = '0;
                n_crc_acc = '0;
                n_got_number = '0;
                n_got_crc_high = '0;
                n_is_long = 1'b0;
                n_poll_elapsed = '0;
                n_phase = PH_HUNT;
                n_segment_elapsed = '0;
                o_res.tx_valid = 1'b1;
                o_res.tx_code = C_REQ;
                o_res.long_block = 1'b0;
            end
            KIND_BYTE: begin
                case (r_phase)
                    PH_HUNT: begin
                        if (i_item.rx_byte == C_SOH || i_item.rx_byte == C_STX) begin
                            n_is_long = (i_item.rx_byte == C_STX);
                            n_byte_count = '0;
                            n_phase = PH_NUMBER;
                            n_segment_elapsed = '0;
                            o_res.long_block = (i_item.rx_byte == C_STX);
                        end else if (i_item.rx_byte == C_EOT) begin
                            o_res.tx_valid = 1'b1;
                            o_res.tx_code = C_ACK;
                            o_res.done_res = 1'b1;
                            o_res.status = ST_EOT;
                            n_phase = PH_IDLE;
                        end else if (i_item.rx_byte == C_CAN || i_item.rx_byte == C_ETX) begin
                            o_res.done_res = 1'b1;
                            o_res.status = ST_CANCEL;
                            n_phase = PH_IDLE;
                        end else begin
                            o_res.tx_valid = 1'b1;
                            o_res.tx_code = C_REQ;
                            n_poll_elapsed = '0;
                        end
                    end
                    PH_NUMBER: begin
                        if (r_byte_count == '0) begin
                            n_got_number = i_item.rx_byte;
                            n_byte_count = CNT_W'(1);
                        end else begin
                            n_byte_count = '0;
                            if (r_got_number != r_expected_number ||
                                i_item.rx_byte != ~r_expected_number) begin
                                o_res.tx_valid = 1'b1;
                                o_res.tx_code = C_NAK;
                                o_res.done_res = 1'b1;
                                o_res.status = ST_BAD_NUM;
                                n_phase = PH_IDLE;
                            end else begin
                                n_crc_acc = '0;
                                n_phase = PH_DATA;
                                n_segment_elapsed = '0;
                            end
                        end
                    end
                    PH_DATA: begin
                        o_res.data_valid = 1'b1;
                        o_res.data_byte = i_item.rx_byte;
                        n_crc_acc = crc_next;
                        n_byte_count = cnt_inc;
                        if (cnt_inc >= block_size) begin
                            n_byte_count = '0;
                            n_phase = PH_CRC;
                            n_segment_elapsed = '0;
                        end
                    end
                    PH_CRC: begin
                        if (r_byte_count == '0) begin
                            n_got_crc_high = i_item.rx_byte;
                            n_byte_count = CNT_W'(1);
                        end else begin
                            n_byte_count = '0;
                            o_res.tx_valid = 1'b1;
                            o_res.done_res = 1'b1;
                            if ({r_got_crc_high, i_item.rx_byte} == r_crc_acc) begin
                                o_res.tx_code = C_ACK;
                                o_res.status = ST_OK;
                            end else begin
                                o_res.tx_code = C_NAK;
                                o_res.status = ST_BAD_CRC;
                            end
                            n_phase = PH_IDLE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            KIND_TICK: begin
                if (r_phase != PH_IDLE) begin
                    n_segment_elapsed = seg_inc;
                    if (seg_inc >= r_segment_timeout) begin
                        o_res.done_res = 1'b1;
                        o_res.status = ST_TIMEOUT;
                        if (r_phase == PH_DATA || r_phase == PH_CRC) begin
                            o_res.tx_valid = 1'b1;
                            o_res.tx_code = C_NAK;
                        end
                        n_phase = PH_IDLE;
                    end else if (r_phase == PH_HUNT) begin
                        n_poll_elapsed = poll_inc;
                        if (poll_inc >= i_poll_interval) begin
                            o_res.tx_valid = 1'b1;
                            o_res.tx_code = C_REQ;
                            n_poll_elapsed = '0;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_byte_count <= '0;
            r_crc_acc <= '0;
            r_expected_number <= '0;
            r_got_number <= '0;
            r_got_crc_high <= '0;
            r_is_long <= 1'b0;
            r_segment_timeout <= '0;
            r_segment_elapsed <= '0;
            r_poll_elapsed <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_byte_count <= n_byte_count;
            r_crc_acc <= n_crc_acc;
            r_expected_number <= n_expected_number;
            r_got_number <= n_got_number;
            r_got_crc_high <= n_got_crc_high;
            r_is_long <= n_is_long;
            r_segment_timeout <= n_segment_timeout;
            r_segment_elapsed <= n_segment_elapsed;
            r_poll_elapsed <= n_poll_elapsed;
        end
    end

endmodule

`default_nettype wire

// File: hdl/xmodem_crc_block_receiver.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir   Payload                                             Transfer
// i_item    in    kind, rx_byte, expected_block, seg_timeout          valid & ready
// o_res     out   tx_valid, tx_code, data_valid, data_byte,           valid & ready
//                 done_res, status, long_block
// cfg       in    i_cfg_wdata = poll interval in ms                   i_cfg_we
//
// One item per cycle sustained while o_res.ready is high; a result passes through the input
// register, then the byte-wise CRC and state update, into the result register.
// Synchronous active-low reset clears the receiver to idle and the poll interval to 500.
// With o_res.ready low the result holds and the input register takes one more item.

module xmodem_crc_block_receiver #(
    parameter int LONG_BLOCK_BYTES = xcbr_pkg::DEF_LONG_BYTES,
    parameter int SHORT_BLOCK_BYTES = xcbr_pkg::DEF_SHORT_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    xcbr_in_if.sink          i_item,
    xcbr_out_if.source       o_res
);
    import xcbr_pkg::*;

    logic [15:0] r_poll_interval;
    logic        r_in_valid;
    t_item       r_in;
    logic        r_out_valid;
    t_res        r_out;
    t_res        core_res;
    logic        advance;

    assign advance = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_item.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_interval <= POLL_RESET;
        end else if (i_cfg_we) begin
            r_poll_interval <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in.kind <= i_item.kind;
            r_in.rx_byte <= i_item.rx_byte;
            r_in.expected_block <= i_item.expected_block;
            r_in.seg_timeout <= i_item.seg_timeout;
        end
    end

    xcbr_core #(
        .LONG_BLOCK_BYTES  (LONG_BLOCK_BYTES),
        .SHORT_BLOCK_BYTES (SHORT_BLOCK_BYTES)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (advance),
        .i_item          (r_in),
        .i_poll_interval (r_poll_interval),
        .o_res           (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_res;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.tx_valid = r_out.tx_valid;
    assign o_res.tx_code = r_out.tx_code;
    assign o_res.data_valid = r_out.data_valid;
    assign o_res.data_byte = r_out.data_byte;
    assign o_res.done_res = r_out.done_res;
    assign o_res.status = r_out.status;
    assign o_res.long_block = r_out.long_block;

endmodule

`default_nettype wire
